@@ hw/rtl/bpsl_pkg.sv @@
// Shared types and constants for the button press and status LED block.
`timescale 1ns / 1ps
`default_nettype none

package bpsl_pkg;

   localparam int TIMER_BITS_DEFAULT = 16;

   localparam int TICK_W  = 10;
   localparam int TIME_W  = 16;
   localparam int LEVEL_W = 2;
   localparam int COLOR_W = 8;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 32;

   // Register reset values.
   localparam logic [TICK_W-1:0]  TICK_PERIOD_RESET  = 10'd20;
   localparam logic [TIME_W-1:0]  LONG_HOLD_RESET    = 16'd2000;
   localparam logic [TIME_W-1:0]  DEBOUNCE_RESET     = 16'd30;
   localparam logic [TIME_W-1:0]  PULSE_PERIOD_RESET = 16'd2000;
   localparam logic [TIME_W-1:0]  PULSE_ON_RESET     = 16'd250;
   localparam logic [TIME_W-1:0]  FLASH_RESET        = 16'd150;
   localparam logic [COLOR_W-1:0] BRIGHTNESS_RESET   = 8'd24;

   // Tick period reduced modulo the pulse period, for the reset values.
   localparam logic [TIME_W-1:0]  TICK_MOD_RESET     = 16'd20;

   localparam logic [LEVEL_W-1:0] LEVEL_WARNING = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_ALARM   = 2'd2;

   typedef enum logic [2:0] {
      REG_TICK_PERIOD  = 3'd0,
      REG_LONG_HOLD    = 3'd1,
      REG_DEBOUNCE     = 3'd2,
      REG_PULSE_PERIOD = 3'd3,
      REG_PULSE_ON     = 3'd4,
      REG_FLASH        = 3'd5,
      REG_BRIGHTNESS   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage

`default_nettype wire

@@ hw/rtl/button_press_and_status_led_top.sv @@
// Top level of the button press classifier and status LED colour generator.
//
//   Channel  Direction  Handshake                Contents
//   req      in         req_tvalid / req_tready  one tick: button, flash, level, recording
//   rsp      out        rsp_tvalid / rsp_tready  one result per tick: press events, colour
//   csr      in/out     APB write and read       seven timing and brightness registers
//
// Each tick's result lands in the output register on the edge that accepts the tick, so
// one tick per cycle is sustained while the result side keeps up and no pass below runs.
// A write of the tick period or the pulse period starts a pass (a start step, the
// bit-serial remainder units working through the dividend bits, and a step that loads their
// results) that reduces the pulse phase and the tick period modulo the pulse period;
// req_tready is low during that pass.
// A result waiting in the output register with rsp_tready low stalls the input side.
// Reset restores the register defaults and clears all press, flash and colour state.
`timescale 1ns / 1ps
`default_nettype none

module button_press_and_status_led_top import bpsl_pkg::*; #(
   parameter int TIMER_BITS = TIMER_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // [0] button_down, [1] flash_request, [3:2] worst_level, [4] recording, [7:5] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [0] label_next, [1] record_request, [2] record_target, [10:3] red,
   // [18:11] green, [26:19] blue, [27] colour_changed, [31:28] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int HW = TIMER_BITS;
   localparam int CW = (TIMER_BITS > TIME_W) ? TIMER_BITS : TIME_W;

   // Configuration registers.
   logic [TICK_W-1:0]  tick_period_ff;
   logic [TIME_W-1:0]  long_hold_ff, debounce_ff, pulse_period_ff, pulse_on_ff, flash_ff;
   logic [COLOR_W-1:0] brightness_ff;

   logic               csr_write;
   csr_index_type      csr_index;

   // Tick state.
   logic               press_active_ff, press_active_in;
   logic               long_fired_ff, long_fired_in;
   logic [HW-1:0]      held_ff, held_in;
   logic [TIME_W-1:0]  flash_left_ff, flash_left_in;
   logic [TIME_W-1:0]  phase_ff, phase_in;
   logic [TIME_W-1:0]  phase_base_ff, phase_base_in;
   logic [TIME_W-1:0]  tick_mod_ff;
   logic [3*COLOR_W-1:0] last_colour_ff, last_colour_in;
   logic               last_valid_ff;

   // Normalization control.
   logic               norm_pending_ff;
   rem_status_type     phase_status, tick_status;
   logic [TIME_W-1:0]  phase_rem, tick_rem;
   logic [TIME_W-1:0]  period_eff;

   // Output register.
   logic               rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic               req_accept;
   logic               down, flash_req, recording;
   logic [LEVEL_W-1:0] level;

   logic [HW:0]        held_sum;
   logic [HW-1:0]      held_adv;
   logic               label_next, record_request, record_target;
   logic               white;
   logic [COLOR_W-1:0] red, green, blue;
   logic               colour_changed;
   logic [TIME_W:0]    phase_sum;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_index)
         REG_TICK_PERIOD:  csr_prdata = CSR_DATA_W'(tick_period_ff);
         REG_LONG_HOLD:    csr_prdata = CSR_DATA_W'(long_hold_ff);
         REG_DEBOUNCE:     csr_prdata = CSR_DATA_W'(debounce_ff);
         REG_PULSE_PERIOD: csr_prdata = CSR_DATA_W'(pulse_period_ff);
         REG_PULSE_ON:     csr_prdata = CSR_DATA_W'(pulse_on_ff);
         REG_FLASH:        csr_prdata = CSR_DATA_W'(flash_ff);
         REG_BRIGHTNESS:   csr_prdata = CSR_DATA_W'(brightness_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff  <= TICK_PERIOD_RESET;
         long_hold_ff    <= LONG_HOLD_RESET;
         debounce_ff     <= DEBOUNCE_RESET;
         pulse_period_ff <= PULSE_PERIOD_RESET;
         pulse_on_ff     <= PULSE_ON_RESET;
         flash_ff        <= FLASH_RESET;
         brightness_ff   <= BRIGHTNESS_RESET;
         norm_pending_ff <= 1'b0;
      end else begin
         norm_pending_ff <= 1'b0;
         if (csr_write) begin
            case (csr_index)
               REG_TICK_PERIOD: begin
                  tick_period_ff  <= csr_pwdata[TICK_W-1:0];
                  norm_pending_ff <= 1'b1;
               end
               REG_LONG_HOLD:    long_hold_ff  <= csr_pwdata[TIME_W-1:0];
               REG_DEBOUNCE:     debounce_ff   <= csr_pwdata[TIME_W-1:0];
               REG_PULSE_PERIOD: begin
                  pulse_period_ff <= csr_pwdata[TIME_W-1:0];
                  norm_pending_ff <= 1'b1;
               end
               REG_PULSE_ON:     pulse_on_ff   <= csr_pwdata[TIME_W-1:0];
               REG_FLASH:        flash_ff      <= csr_pwdata[TIME_W-1:0];
               REG_BRIGHTNESS:   brightness_ff <= csr_pwdata[COLOR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // ------------------------------------------------- phase normalization
   // A period of zero behaves as one.
   assign period_eff = (pulse_period_ff == '0) ? TIME_W'(1) : pulse_period_ff;

   bpsl_rem_unit u_phase_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (norm_pending_ff),
      .dividend  (phase_ff),
      .divisor   (period_eff),
      .status    (phase_status),
      .remainder (phase_rem)
   );

   bpsl_rem_unit u_tick_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (norm_pending_ff),
      .dividend  (TIME_W'(tick_period_ff)),
      .divisor   (period_eff),
      .status    (tick_status),
      .remainder (tick_rem)
   );

   // ------------------------------------------------------------ handshake
   // The input also waits out the cycle in which the reduced values are loaded.
   assign req_tready = !norm_pending_ff && !phase_status.busy && !tick_status.busy
                       && !phase_status.done && !tick_status.done
                       && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;

   assign down      = req_tdata[0];
   assign flash_req = req_tdata[1];
   assign level     = req_tdata[3:2];
   assign recording = req_tdata[4];

   // ------------------------------------------------------------ tick logic
   always_comb begin
      held_sum = {1'b0, held_ff} + (HW+1)'(tick_period_ff);
      held_adv = held_ff;
      if (press_active_ff) begin
         held_adv = held_sum[HW] ? '1 : held_sum[HW-1:0];
      end

      flash_left_in = (flash_left_ff > TIME_W'(tick_period_ff))
                      ? flash_left_ff - TIME_W'(tick_period_ff) : '0;
      if (flash_req) begin
         flash_left_in = flash_ff;
      end

      press_active_in = press_active_ff;
      long_fired_in   = long_fired_ff;
      held_in         = held_adv;
      label_next      = 1'b0;
      record_request  = 1'b0;
      record_target   = 1'b0;
      if (down && !press_active_ff) begin
         press_active_in = 1'b1;
         held_in         = '0;
         long_fired_in   = 1'b0;
      end else if (down && !long_fired_ff && (CW'(held_adv) >= CW'(long_hold_ff))) begin
         long_fired_in  = 1'b1;
         record_request = 1'b1;
         record_target  = !recording;
      end else if (!down && press_active_ff) begin
         label_next      = !long_fired_ff && (CW'(held_adv) >= CW'(debounce_ff));
         press_active_in = 1'b0;
      end

      white = (flash_left_in != '0)
              || (down && press_active_in && (CW'(held_in) >= CW'(long_hold_ff)));

      red   = '0;
      green = '0;
      blue  = '0;
      if (white) begin
         red   = brightness_ff;
         green = brightness_ff;
         blue  = brightness_ff;
      end else if (phase_ff < pulse_on_ff) begin
         if (level == LEVEL_ALARM) begin
            red = brightness_ff;
         end else if (level == LEVEL_WARNING) begin
            red   = brightness_ff;
            green = {1'b0, brightness_ff[COLOR_W-1:1]};
         end else if (recording) begin
            green = brightness_ff;
         end else begin
            blue = brightness_ff;
         end
      end

      last_colour_in = {red, green, blue};
      colour_changed = !last_valid_ff || (last_colour_in != last_colour_ff);

      // Base and step are both below the period, so one subtraction wraps the sum.
      phase_sum = {1'b0, phase_base_ff} + {1'b0, tick_mod_ff};
      if (phase_sum >= {1'b0, period_eff}) begin
         phase_sum = phase_sum - {1'b0, period_eff};
      end
      phase_in      = phase_sum[TIME_W-1:0];
      phase_base_in = phase_sum[TIME_W-1:0];

      rsp_data_in = RSP_DATA_W'({colour_changed, blue, green, red,
                                 record_target, record_request, label_next});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_active_ff <= 1'b0;
         long_fired_ff   <= 1'b0;
         held_ff         <= '0;
         flash_left_ff   <= '0;
         phase_ff        <= '0;
         phase_base_ff   <= '0;
         tick_mod_ff     <= TICK_MOD_RESET;
         last_colour_ff  <= '0;
         last_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (phase_status.done) begin
            phase_base_ff <= phase_rem;
         end
         if (tick_status.done) begin
            tick_mod_ff <= tick_rem;
         end
         if (req_accept) begin
            press_active_ff <= press_active_in;
            long_fired_ff   <= long_fired_in;
            held_ff         <= held_in;
            flash_left_ff   <= flash_left_in;
            phase_ff        <= phase_in;
            phase_base_ff   <= phase_base_in;
            last_colour_ff  <= last_colour_in;
            last_valid_ff   <= 1'b1;
            rsp_valid_ff    <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/bpsl_rem_unit.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module bpsl_rem_unit import bpsl_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [TIME_W-1:0] dividend,
   input  wire logic [TIME_W-1:0] divisor,
   output rem_status_type         status,
   output logic [TIME_W-1:0]      remainder
);

   localparam int CNT_W = $clog2(TIME_W + 1);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              done_ff, done_in;
   logic [TIME_W-1:0] shift_ff, shift_in;
   logic [TIME_W-1:0] divisor_ff, divisor_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W:0]   trial;

   always_comb begin
      count_in   = count_ff;
      done_in    = 1'b0;
      shift_in   = shift_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      trial      = {rem_ff, shift_ff[TIME_W-1]};
      if (start) begin
         count_in   = CNT_W'(TIME_W);
         shift_in   = dividend;
         divisor_in = divisor;
         rem_in     = '0;
      end else if (count_ff != '0) begin
         // The partial remainder stays below the divisor, so it fits the narrow register.
         if (trial >= {1'b0, divisor_ff}) begin
            trial = trial - {1'b0, divisor_ff};
         end
         rem_in   = trial[TIME_W-1:0];
         shift_in = {shift_ff[TIME_W-2:0], 1'b0};
         count_in = count_ff - 1'b1;
         done_in  = (count_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      shift_ff   <= shift_in;
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire
